// ===== design/ffr_pkg.sv =====
// Shared types and constants for the four-field framed receiver.
// No dependencies; every other design file imports this package.
package ffr_pkg;

	localparam int FRAME_LIMIT_DEF = 256;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] FIRST_HEADER_RST = 8'h2C;
	localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'h12;
	localparam logic [BYTE_W-1:0] TRAILER_BYTE_RST = 8'h5B;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRAILER_BYTE = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_WAIT2 = 4'b0010,
		PH_COLLECT = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic we;
		logic [CFG_IDX_W-1:0] index;
		logic [BYTE_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [BYTE_W-1:0] angle_value;
		logic [BYTE_W-1:0] pos_x;
		logic [BYTE_W-1:0] pos_y;
		logic [BYTE_W-1:0] road_code;
	} result_t;

endpackage

// ===== design/four_field_framed_receiver.sv =====
// Top level of the four-field framed receiver; uses ffr_pkg, ffr_in_stage,
// ffr_parser and ffr_out_stage.
//
// Accepts one received byte every clock cycle unless a held result is not
// being taken. A byte waits in the input register for a parser step, and a
// step on a trailer loads its result into the output register. The parser's
// phase, count and window change only on a step, which runs whenever the
// input register holds a byte and the output register is empty or is being
// emptied, so a stalled consumer stalls input only while a result is held
// there. Sync and trailer bytes are written through cfg_we, cfg_index and
// cfg_data; the user must do so while idle; the block does not enforce it.
module four_field_framed_receiver #(
	parameter int FRAME_LIMIT = ffr_pkg::FRAME_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ffr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ffr_pkg::BYTE_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [ffr_pkg::BYTE_W-1:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [ffr_pkg::BYTE_W-1:0] angle_value,
	output logic [ffr_pkg::BYTE_W-1:0] pos_x,
	output logic [ffr_pkg::BYTE_W-1:0] pos_y,
	output logic [ffr_pkg::BYTE_W-1:0] road_code
);
	import ffr_pkg::*;

	cfg_wr_t cfg;
	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic slot_free;
	logic step;
	logic hit;
	result_t result;
	result_t result_q;

	assign cfg.we = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;

	assign step = valid_s1 && slot_free;

	ffr_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.take(step),
		.valid_s1(valid_s1),
		.byte_s1(byte_s1)
	);

	ffr_parser #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step(step),
		.byte_s1(byte_s1),
		.hit(hit),
		.result(result)
	);

	ffr_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(hit),
		.result(result),
		.slot_free(slot_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_q(result_q)
	);

	assign angle_value = result_q.angle_value;
	assign pos_x = result_q.pos_x;
	assign pos_y = result_q.pos_y;
	assign road_code = result_q.road_code;

endmodule

// ===== design/ffr_in_stage.sv =====
// Input register of the framed receiver: holds one received byte.
// Depends on ffr_pkg.
module ffr_in_stage (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [ffr_pkg::BYTE_W-1:0] rx_byte,
	input logic take,
	output logic valid_s1,
	output logic [ffr_pkg::BYTE_W-1:0] byte_s1
);
	import ffr_pkg::*;

	// The register refills in the same cycle that its byte moves on.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ===== design/ffr_parser.sv =====
// Frame parser: sync registers, phase, frame byte count and the last four frame bytes.
// Depends on ffr_pkg.
module ffr_parser #(
	parameter int FRAME_LIMIT = ffr_pkg::FRAME_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	input ffr_pkg::cfg_wr_t cfg,
	input logic step,
	input logic [ffr_pkg::BYTE_W-1:0] byte_s1,
	output logic hit,
	output ffr_pkg::result_t result
);
	import ffr_pkg::*;

	localparam int CNT_W = $clog2(FRAME_LIMIT + 1);

	logic [BYTE_W-1:0] first_header_q, second_header_q, trailer_byte_q;
	phase_t phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [BYTE_W-1:0] recent_q [4];
	logic [BYTE_W-1:0] recent_d [4];
	logic hit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_header_q <= FIRST_HEADER_RST;
			second_header_q <= SECOND_HEADER_RST;
			trailer_byte_q <= TRAILER_BYTE_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				REG_FIRST_HEADER: first_header_q <= cfg.data;
				REG_SECOND_HEADER: second_header_q <= cfg.data;
				REG_TRAILER_BYTE: trailer_byte_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		recent_d = recent_q;
		hit_d = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == first_header_q) phase_d = PH_WAIT2;
			end
			PH_WAIT2: begin
				// The second header is frame byte 0 and enters an otherwise empty window.
				if (byte_s1 == second_header_q) begin
					recent_d[0] = '0;
					recent_d[1] = '0;
					recent_d[2] = '0;
					recent_d[3] = byte_s1;
					count_d = CNT_W'(1);
					phase_d = PH_COLLECT;
				end
			end
			PH_COLLECT: begin
				count_d = count_q + CNT_W'(1);
				if (byte_s1 == trailer_byte_q) begin
					hit_d = 1'b1;
					phase_d = PH_DONE;
				end else begin
					recent_d[0] = recent_q[1];
					recent_d[1] = recent_q[2];
					recent_d[2] = recent_q[3];
					recent_d[3] = byte_s1;
				end
			end
			default: begin
				// The byte after a finished frame is dropped.
				count_d = '0;
				recent_d[0] = '0;
				recent_d[1] = '0;
				recent_d[2] = '0;
				recent_d[3] = '0;
				phase_d = PH_IDLE;
			end
		endcase
		// An over-long frame is abandoned without a result, after any trailer result.
		if (count_d >= CNT_W'(FRAME_LIMIT)) begin
			count_d = '0;
			recent_d[0] = '0;
			recent_d[1] = '0;
			recent_d[2] = '0;
			recent_d[3] = '0;
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			recent_q[0] <= '0;
			recent_q[1] <= '0;
			recent_q[2] <= '0;
			recent_q[3] <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			recent_q <= recent_d;
		end
	end

	assign hit = step && hit_d;
	assign result.angle_value = recent_q[0];
	assign result.pos_x = recent_q[1];
	assign result.pos_y = recent_q[2];
	assign result.road_code = recent_q[3];

endmodule

// ===== design/ffr_out_stage.sv =====
// Result register of the framed receiver: holds one finished item until it is taken.
// Depends on ffr_pkg.
module ffr_out_stage (
	input logic clk,
	input logic arst_n,
	input logic load,
	input ffr_pkg::result_t result,
	output logic slot_free,
	output logic out_valid,
	input logic out_ready,
	output ffr_pkg::result_t result_q
);
	import ffr_pkg::*;

	logic valid_q;

	// A held item that is being taken this cycle frees the slot for the next one.
	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

// ===== design/ffr_checker.sv =====
// Port-level checks for the four-field framed receiver, bound to its top level.
// Depends on ffr_pkg and four_field_framed_receiver.
module ffr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [ffr_pkg::BYTE_W-1:0] angle_value,
	input logic [ffr_pkg::BYTE_W-1:0] pos_x,
	input logic [ffr_pkg::BYTE_W-1:0] pos_y,
	input logic [ffr_pkg::BYTE_W-1:0] road_code
);
	import ffr_pkg::*;

	// A held item keeps its fields until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle_value) && $stable(pos_x)
			&& $stable(pos_y) && $stable(road_code))
		else $error("result item changed while stalled");

	// A new result always comes from an earlier accepted input byte.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result item without a matching input item");

	// Input is never stalled while the output side drains.
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output ready");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

endmodule

bind four_field_framed_receiver ffr_checker u_ffr_checker (.*);
